>>> rtl/spkint_pkg.sv
// Shared types and constants for the spectral peak interpolator.
// No dependencies; every other file in rtl/ imports this package.
package spkint_pkg;

    // Frame length in bins; only the lower half of the spectrum is searched.
    localparam int unsigned BINS      = 512;
    localparam int unsigned HALF_BINS = BINS / 2;

    localparam int unsigned IDX_W  = 12;
    localparam int unsigned MAG_W  = 32;
    localparam int unsigned BW_W   = 24;
    localparam int unsigned FREQ_W = 24;
    localparam int unsigned AMP_W  = 32;

    localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF_BINS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HALF_BINS - 1);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [IDX_W-1:0] START_RST = 12'd0;
    localparam logic [IDX_W-1:0] END_RST   = 12'd256;
    localparam logic [BW_W-1:0]  WIDTH_RST = 24'd24000;

    // Frame record queue; the depth must be a power of two.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Interpolation arithmetic widths.
    localparam int unsigned NUM_W  = 33;   // y0 - y2
    localparam int unsigned DEN_W  = 35;   // y0 - 2*y1 + y2
    localparam int unsigned ADEN_W = 34;   // |den|
    localparam int unsigned DIV_W  = 52;   // remainder and shifted divisor
    localparam int unsigned QUO_W  = 17;   // Q16 offset magnitude
    localparam int unsigned OFS_W  = 18;   // signed Q16 offset
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned POS_W  = 28;   // index.Q16 position
    localparam int unsigned FPROD_W = POS_W + BW_W;
    localparam int unsigned APROD_W = NUM_W + OFS_W;
    localparam int unsigned VAL_W  = 52;

    localparam logic [QUO_W-1:0] Q16_ONE = 17'd65536;
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = 5'd16;

    // One finished frame, handed from the front end to the back end.
    typedef struct packed {
        logic [IDX_W-1:0] best_index;
        logic [MAG_W-1:0] y0;
        logic [MAG_W-1:0] y1;
        logic [MAG_W-1:0] y2;
        logic             found;
        logic             at_edge;
    } spkint_rec_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } spkint_qstat_t;

    typedef struct packed {
        logic              found;
        logic [AMP_W-1:0]  amplitude;
        logic [FREQ_W-1:0] frequency;
    } spkint_res_t;

endpackage

>>> rtl/spkint_front.sv
// Front end: takes one magnitude bin per transfer and tracks the peak search.
// Depends on spkint_pkg; pushes one spkint_rec_t per frame into spkint_queue.
module spkint_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spkint_pkg::MAG_W-1:0] s_tdata,
    input  logic                         s_tlast,
    input  logic [spkint_pkg::IDX_W-1:0] start_bin,
    input  logic [spkint_pkg::IDX_W-1:0] end_bin,
    input  spkint_pkg::spkint_qstat_t    qstat,
    output logic                         push,
    output spkint_pkg::spkint_rec_t      rec
);
    import spkint_pkg::*;

    logic [IDX_W-1:0] bin_cnt_reg, bin_cnt_next;
    logic [MAG_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             have_best_reg, have_best_next;
    logic [MAG_W-1:0] prev_bin_reg, prev_bin_next;
    logic [MAG_W-1:0] left_reg, left_next;
    logic [MAG_W-1:0] right_reg, right_next;
    logic             right_pend_reg, right_pend_next;

    logic             accept;
    logic [IDX_W-1:0] hi;
    logic             hit;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign hi       = (end_bin < HALF_IDX) ? end_bin : HALF_IDX;
    assign hit      = (bin_cnt_reg >= start_bin) && (bin_cnt_reg < hi)
                      && (!have_best_reg || (s_tdata > best_val_reg));

    // Search update for the bin being taken, before the end-of-frame clear.
    logic [IDX_W-1:0] upd_cnt;
    logic [MAG_W-1:0] upd_best_val;
    logic [IDX_W-1:0] upd_best_idx;
    logic             upd_have;
    logic [MAG_W-1:0] upd_left;
    logic [MAG_W-1:0] upd_right;
    logic             upd_pend;

    always_comb
    begin
        upd_right    = right_pend_reg ? s_tdata : right_reg;
        upd_pend     = 1'b0;
        upd_best_val = best_val_reg;
        upd_best_idx = best_idx_reg;
        upd_have     = have_best_reg;
        upd_left     = left_reg;
        if (hit)
        begin
            upd_have     = 1'b1;
            upd_best_val = s_tdata;
            upd_best_idx = bin_cnt_reg;
            upd_left     = prev_bin_reg;
            upd_right    = '0;
            upd_pend     = 1'b1;
        end
        upd_cnt = (bin_cnt_reg != '1) ? bin_cnt_reg + IDX_W'(1) : bin_cnt_reg;
    end

    assign push           = accept && s_tlast;
    assign rec.best_index = upd_best_idx;
    assign rec.y0         = upd_left;
    assign rec.y1         = upd_best_val;
    assign rec.y2         = upd_right;
    assign rec.found      = (start_bin < hi) && upd_have;
    assign rec.at_edge    = (upd_best_idx == '0) || (upd_best_idx == LAST_IDX);

    always_comb
    begin
        bin_cnt_next    = bin_cnt_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        have_best_next  = have_best_reg;
        prev_bin_next   = prev_bin_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        right_pend_next = right_pend_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                bin_cnt_next    = '0;
                best_val_next   = '0;
                best_idx_next   = '0;
                have_best_next  = 1'b0;
                prev_bin_next   = '0;
                left_next       = '0;
                right_next      = '0;
                right_pend_next = 1'b0;
            end
            else
            begin
                bin_cnt_next    = upd_cnt;
                best_val_next   = upd_best_val;
                best_idx_next   = upd_best_idx;
                have_best_next  = upd_have;
                prev_bin_next   = s_tdata;
                left_next       = upd_left;
                right_next      = upd_right;
                right_pend_next = upd_pend;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg    <= '0;
            best_val_reg   <= '0;
            best_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
            prev_bin_reg   <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            right_pend_reg <= 1'b0;
        end
        else
        begin
            bin_cnt_reg    <= bin_cnt_next;
            best_val_reg   <= best_val_next;
            best_idx_reg   <= best_idx_next;
            have_best_reg  <= have_best_next;
            prev_bin_reg   <= prev_bin_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            right_pend_reg <= right_pend_next;
        end
    end

endmodule

>>> rtl/spkint_queue.sv
// Short FIFO of finished frame records between the front and back ends.
// Depends on spkint_pkg for the record type and the queue depth.
module spkint_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  spkint_pkg::spkint_rec_t   wr_rec,
    input  logic                      pop,
    output spkint_pkg::spkint_rec_t   head,
    output spkint_pkg::spkint_qstat_t qstat
);
    import spkint_pkg::*;

    spkint_rec_t        mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign qstat.not_empty = (count_reg != '0);
    assign qstat.full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push         = push && !qstat.full;
    assign do_pop          = pop && qstat.not_empty;
    assign head            = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/spkint_back.sv
// Back end: parabolic refinement of one frame record and the output register.
// Depends on spkint_pkg; pops records from spkint_queue.
module spkint_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [spkint_pkg::BW_W-1:0]  bin_width,
    input  spkint_pkg::spkint_qstat_t    qstat,
    input  spkint_pkg::spkint_rec_t      head,
    output logic                         pop,
    output logic                         res_valid,
    input  logic                         res_ready,
    output spkint_pkg::spkint_res_t      res
);
    import spkint_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_MUL,
        S_AMP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [MAG_W-1:0]          y1_reg, y1_next;
    logic                      found_reg, found_next;
    logic                      interp_reg, interp_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic signed [DEN_W-1:0]   den_reg, den_next;
    logic                      sign_reg, sign_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [DIV_W-1:0]          dsh_reg, dsh_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [OFS_W-1:0]   ofs_reg, ofs_next;
    logic [FPROD_W-1:0]        fprod_reg, fprod_next;
    logic signed [APROD_W-1:0] aprod_reg, aprod_next;
    logic [FREQ_W-1:0]         freq_reg, freq_next;
    logic [VAL_W-1:0]          aval_reg, aval_next;
    spkint_res_t               res_reg, res_next;

    logic signed [DEN_W-1:0]   aden_full;
    logic signed [NUM_W-1:0]   anum_full;
    logic [QUO_W-1:0]          quo_sat;
    logic signed [POS_W:0]     pos_s;
    logic [POS_W-1:0]          pos_u;
    logic [FPROD_W:0]          fsum;
    logic signed [VAL_W-1:0]   val_s;
    logic [VAL_W:0]            asum;
    logic                      rem_ge;

    assign aden_full = den_reg[DEN_W-1] ? -den_reg : den_reg;
    assign anum_full = num_reg[NUM_W-1] ? -num_reg : num_reg;
    assign rem_ge    = (rem_reg >= dsh_reg);
    assign quo_sat   = (quo_reg > Q16_ONE) ? Q16_ONE : quo_reg;
    assign pos_s     = $signed({1'b0, idx_reg, 16'b0})
                       + $signed({{(POS_W + 1 - OFS_W){ofs_reg[OFS_W-1]}}, ofs_reg});
    assign pos_u     = pos_s[POS_W] ? '0 : pos_s[POS_W-1:0];
    assign fsum      = {1'b0, fprod_reg} + (FPROD_W + 1)'(32768);
    assign val_s     = $signed({3'b000, y1_reg, 17'b0})
                       - $signed({aprod_reg[APROD_W-1], aprod_reg});
    assign asum      = {1'b0, aval_reg} + (VAL_W + 1)'(65536);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res_ready;
        pop            = 1'b0;
        idx_next       = idx_reg;
        y1_next        = y1_reg;
        found_next     = found_reg;
        interp_next    = interp_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        sign_next      = sign_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        ofs_next       = ofs_reg;
        fprod_next     = fprod_reg;
        aprod_next     = aprod_reg;
        freq_next      = freq_reg;
        aval_next      = aval_reg;
        res_next       = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (qstat.not_empty)
                begin
                    pop         = 1'b1;
                    idx_next    = head.best_index;
                    y1_next     = head.y1;
                    found_next  = head.found;
                    interp_next = head.found && !head.at_edge;
                    num_next    = $signed({1'b0, head.y0}) - $signed({1'b0, head.y2});
                    den_next    = $signed({3'b000, head.y0}) + $signed({3'b000, head.y2})
                                  - $signed({2'b00, head.y1, 1'b0});
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                sign_next = num_reg[NUM_W-1] ^ den_reg[DEN_W-1];
                rem_next  = DIV_W'({anum_full[MAG_W-1:0], 16'b0})
                            + DIV_W'(aden_full[ADEN_W-1:0]);
                dsh_next  = {aden_full[ADEN_W-1:0], 18'b0};
                quo_next  = '0;
                ofs_next  = '0;
                // Edge peaks, frames without a peak and a flat parabola use no offset.
                if (!interp_reg || (den_reg == '0))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // A quotient of two bins or more saturates without dividing.
                if (rem_ge)
                begin
                    quo_next   = Q16_ONE;
                    state_next = S_SIGN;
                end
                else
                begin
                    dsh_next   = dsh_reg >> 1;
                    cnt_next   = DIV_LAST_STEP;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[QUO_W-2:0], rem_ge};
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_SIGN:
            begin
                ofs_next   = sign_reg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
                state_next = S_MUL;
            end
            S_MUL:
            begin
                fprod_next = {{BW_W{1'b0}}, pos_u} * {{POS_W{1'b0}}, bin_width};
                aprod_next = $signed({{OFS_W{num_reg[NUM_W-1]}}, num_reg})
                             * $signed({{NUM_W{ofs_reg[OFS_W-1]}}, ofs_reg});
                state_next = S_AMP;
            end
            S_AMP:
            begin
                freq_next  = (|fsum[FPROD_W:FREQ_W+16]) ? '1 : fsum[FREQ_W+15:16];
                aval_next  = val_s[VAL_W-1] ? VAL_W'(-val_s) : VAL_W'(val_s);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    res_next.found = found_reg;
                    if (found_reg)
                    begin
                        res_next.frequency = freq_reg;
                        res_next.amplitude = (|asum[VAL_W:AMP_W+17]) ? '1
                                             : asum[AMP_W+16:17];
                    end
                    else
                    begin
                        res_next.frequency = '0;
                        res_next.amplitude = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        y1_reg     <= y1_next;
        found_reg  <= found_next;
        interp_reg <= interp_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        sign_reg   <= sign_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        ofs_reg    <= ofs_next;
        fprod_reg  <= fprod_next;
        aprod_reg  <= aprod_next;
        freq_reg   <= freq_next;
        aval_reg   <= aval_next;
        res_reg    <= res_next;
    end

endmodule

>>> rtl/spectral_peak_interpolator_unit.sv
// Top level of the spectral peak interpolator: configuration registers and
// the front end, frame queue and back end. Depends on spkint_pkg,
// spkint_front, spkint_queue and spkint_back.
//
//   Channel   Signals                                 Bits  Carries
//   --------  --------------------------------------  ----  -----------------------------
//   s_*       s_tvalid s_tready s_tdata s_tlast         32  one magnitude bin, tlast = last
//   m_*       m_tvalid m_tready m_tdata m_tuser         56  one peak result per frame
//   cfg_*     cfg_valid cfg_ready cfg_index cfg_data    24  register write
//
// Bins are taken one per cycle while the frame queue has room. At each frame
// end the back end steps through setup, range check, bit-serial offset divider,
// sign, multiply, amplitude and output; saturation skips the divider, and a
// frame needing no division skips the check too. The two-entry queue lets the
// next frame stream in meanwhile. The result waits in an output register that
// m_tready drains. rst_n resets asynchronously; there is no clearing pass.
module spectral_peak_interpolator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,    // [31:0] magnitude
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata,    // [23:0] peak_frequency,
                                                          // [55:24] peak_amplitude
    output logic [0:0]                        m_tuser,    // [0] found
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spkint_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spkint_pkg::CFG_DATA_W-1:0] cfg_data
);
    import spkint_pkg::*;

    // Configuration registers. Writes are expected only while the block is
    // idle, so the back end may read bin_width live at frame end.
    logic [IDX_W-1:0] start_bin_reg, start_bin_next;
    logic [IDX_W-1:0] end_bin_reg, end_bin_next;
    logic [BW_W-1:0]  bin_width_reg, bin_width_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_bin_next = start_bin_reg;
        end_bin_next   = end_bin_reg;
        bin_width_next = bin_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START: start_bin_next = cfg_data[IDX_W-1:0];
                CFG_END:   end_bin_next   = cfg_data[IDX_W-1:0];
                CFG_WIDTH: bin_width_next = cfg_data[BW_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bin_reg <= START_RST;
            end_bin_reg   <= END_RST;
            bin_width_reg <= WIDTH_RST;
        end
        else
        begin
            start_bin_reg <= start_bin_next;
            end_bin_reg   <= end_bin_next;
            bin_width_reg <= bin_width_next;
        end
    end

    // The front end closes a frame record on the last bin; the queue holds
    // it until the back end is free to refine it.
    spkint_qstat_t qstat;
    spkint_rec_t   wr_rec;
    spkint_rec_t   head;
    spkint_res_t   res;
    logic          push;
    logic          pop;

    spkint_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .start_bin (start_bin_reg),
        .end_bin   (end_bin_reg),
        .qstat     (qstat),
        .push      (push),
        .rec       (wr_rec)
    );

    spkint_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .head   (head),
        .qstat  (qstat)
    );

    spkint_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_width (bin_width_reg),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Output packing: frequency in the low bits, amplitude above it.
    assign m_tdata    = {res.amplitude, res.frequency};
    assign m_tuser[0] = res.found;

    // A result without a peak must carry all-zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("result without a peak carries nonzero data");

    // A frame closing transfer must leave a record waiting in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> qstat.not_empty)
        else $error("frame record lost at frame end");

endmodule
